// ===== rtl/adpcm_pkg.sv =====
// ----------------------------------------------------------------------------
// ADPCM decoder package
// Shared widths, types and register indexes of the ADPCM decoder core.
// ----------------------------------------------------------------------------
package adpcm_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PACK_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PACK_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PACK_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PACK_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_NEWER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_OLDER = 3'd5;

    // Stream widths
    localparam int BYTE_W   = 8;
    localparam int PCM_W    = 16;
    localparam int NIBBLE_W = 4;
    localparam int POS_W    = 3;

    typedef logic signed [PCM_W-1:0] t_pcm;
    typedef logic [NIBBLE_W-1:0]     t_nibble;

    // Predictor settings for the current header
    typedef struct packed {
        t_pcm c1;
        t_pcm c2;
        t_pcm start_newer;
        t_pcm start_older;
    } t_pred_cfg;

endpackage

// ===== rtl/dsp_adpcm_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ADPCM decoder core
// Decodes 4-bit ADPCM frames of 8 bytes into saturated 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one encoded byte per transaction on i_s_tdata. i_s_tuser
//   restarts the stream (history reloaded from the start registers, byte taken
//   as a frame header); i_s_tlast marks the stream end, so that data byte
//   yields only its high-nibble sample.
//   Output stream: one PCM sample per transaction; o_m_tlast flags the final
//   sample of its byte.
//   Header bytes produce nothing. A data byte yields one sample per cycle
//   through the single sample unit when the receiver does not stall; the history
//   dependency between the two samples of a byte serializes them.
//   A sample appears on the output in the cycle after its calculation cycle.
//   A taken byte passes the byte register, its samples the output register.
//   When the receiver stalls, the output register holds its sample, the
//   sample unit waits, and o_s_tready drops once the byte in work is pending.
//   Reset clears history, header, frame position and all configuration.
//   Configuration writes go through i_cfg_we/i_cfg_index/i_cfg_data; the user
//   must write only while the core is idle, which the core does not enforce.
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [adpcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adpcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Encoded stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] stream_byte
    input  logic                              i_s_tuser,   // [0] restart
    input  logic                              i_s_tlast,   // final_half
    // PCM stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [15:0]                       o_m_tdata,   // [15:0] pcm_sample
    output logic                              o_m_tlast    // last_of_byte
);
    import adpcm_pkg::*;

    // Decoder state
    t_pcm              r_hist_newer, n_hist_newer;
    t_pcm              r_hist_older, n_hist_older;
    logic [BYTE_W-1:0] r_header,     n_header;
    logic [POS_W-1:0]  r_pos,        n_pos;
    // Byte in work
    logic              r_busy,       n_busy;
    logic [BYTE_W-1:0] r_byte,       n_byte;
    logic              r_final,      n_final;
    logic              r_phase,      n_phase;
    // Output register
    logic              r_out_valid,  n_out_valid;
    t_pcm              r_out_pcm,    n_out_pcm;
    logic              r_out_last,   n_out_last;

    t_pred_cfg         w_pred_cfg;
    t_nibble           w_nibble;
    t_pcm              w_sample;
    logic              w_step;
    logic              w_done;
    logic              w_accept;
    logic [POS_W-1:0]  w_pos_eff;

    adpcm_coef_regs u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pair      (r_header[6:4]),
        .o_pred_cfg  (w_pred_cfg)
    );

    // High nibble first, then low nibble
    assign w_nibble = r_phase ? r_byte[3:0] : r_byte[7:4];

    adpcm_sample_calc u_sample_calc (
        .i_nibble (w_nibble),
        .i_shift  (r_header[3:0]),
        .i_c1     (w_pred_cfg.c1),
        .i_c2     (w_pred_cfg.c2),
        .i_newer  (r_hist_newer),
        .i_older  (r_hist_older),
        .o_sample (w_sample)
    );

    // Handshake
    assign w_step     = r_busy && (!r_out_valid || i_m_tready);
    assign w_done     = w_step && (r_phase || r_final);
    assign o_s_tready = !r_busy || w_done;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_pos_eff  = i_s_tuser ? '0 : r_pos;

    always_comb begin
        n_hist_newer = r_hist_newer;
        n_hist_older = r_hist_older;
        n_header     = r_header;
        n_pos        = r_pos;
        n_busy       = r_busy;
        n_byte       = r_byte;
        n_final      = r_final;
        n_phase      = r_phase;
        n_out_valid  = r_out_valid;
        n_out_pcm    = r_out_pcm;
        n_out_last   = r_out_last;

        // Drain the output register
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        // Produce one sample and shift history
        if (w_step) begin
            n_out_valid  = 1'b1;
            n_out_pcm    = w_sample;
            n_out_last   = r_phase || r_final;
            n_hist_older = r_hist_newer;
            n_hist_newer = w_sample;
            if (w_done) begin
                n_busy = 1'b0;
            end else begin
                n_phase = 1'b1;
            end
        end

        // Take a new byte; restart reloads history after any sample above
        if (w_accept) begin
            if (i_s_tuser) begin
                n_hist_newer = w_pred_cfg.start_newer;
                n_hist_older = w_pred_cfg.start_older;
            end
            if (w_pos_eff == '0) begin
                n_header = i_s_tdata;
                n_pos    = POS_W'(1);
            end else begin
                n_pos   = w_pos_eff + POS_W'(1);
                n_busy  = 1'b1;
                n_byte  = i_s_tdata;
                n_final = i_s_tlast;
                n_phase = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_newer <= '0;
            r_hist_older <= '0;
            r_header     <= '0;
            r_pos        <= '0;
            r_busy       <= 1'b0;
            r_phase      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hist_newer <= n_hist_newer;
            r_hist_older <= n_hist_older;
            r_header     <= n_header;
            r_pos        <= n_pos;
            r_busy       <= n_busy;
            r_phase      <= n_phase;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_final    <= n_final;
        r_out_pcm  <= n_out_pcm;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pcm;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/adpcm_coef_regs.sv =====
// ----------------------------------------------------------------------------
// ADPCM coefficient registers
// Holds the coefficient packs and restart history, selects the pair for the
// current header.
// ----------------------------------------------------------------------------
module adpcm_coef_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [adpcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adpcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [2:0]                        i_pair,
    output adpcm_pkg::t_pred_cfg              o_pred_cfg
);
    import adpcm_pkg::*;

    logic [CFG_DATA_W-1:0] r_pack [4];
    t_pcm                  r_start_newer;
    t_pcm                  r_start_older;
    logic [CFG_DATA_W-1:0] w_pack;

    // Write registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack[0]     <= '0;
            r_pack[1]     <= '0;
            r_pack[2]     <= '0;
            r_pack[3]     <= '0;
            r_start_newer <= '0;
            r_start_older <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COEF_PACK_A: r_pack[0] <= i_cfg_data;
                REG_COEF_PACK_B: r_pack[1] <= i_cfg_data;
                REG_COEF_PACK_C: r_pack[2] <= i_cfg_data;
                REG_COEF_PACK_D: r_pack[3] <= i_cfg_data;
                REG_START_NEWER: r_start_newer <= t_pcm'(i_cfg_data[PCM_W-1:0]);
                REG_START_OLDER: r_start_older <= t_pcm'(i_cfg_data[PCM_W-1:0]);
                default: ;
            endcase
        end
    end

    // Pair p sits in pack p/2, upper or lower half by the low bit of p
    assign w_pack = r_pack[i_pair[2:1]];

    always_comb begin
        if (i_pair[0]) begin
            o_pred_cfg.c1 = t_pcm'(w_pack[47:32]);
            o_pred_cfg.c2 = t_pcm'(w_pack[63:48]);
        end else begin
            o_pred_cfg.c1 = t_pcm'(w_pack[15:0]);
            o_pred_cfg.c2 = t_pcm'(w_pack[31:16]);
        end
        o_pred_cfg.start_newer = r_start_newer;
        o_pred_cfg.start_older = r_start_older;
    end

endmodule

// ===== rtl/adpcm_sample_calc.sv =====
// ----------------------------------------------------------------------------
// ADPCM sample calculation
// One sample: scaled nibble plus rounded second-order prediction, saturated.
// ----------------------------------------------------------------------------
module adpcm_sample_calc (
    input  adpcm_pkg::t_nibble i_nibble,
    input  logic [3:0]         i_shift,
    input  adpcm_pkg::t_pcm    i_c1,
    input  adpcm_pkg::t_pcm    i_c2,
    input  adpcm_pkg::t_pcm    i_newer,
    input  adpcm_pkg::t_pcm    i_older,
    output adpcm_pkg::t_pcm    o_sample
);
    import adpcm_pkg::*;

    localparam logic signed [23:0] SAT_MAX = 24'sd32767;
    localparam logic signed [23:0] SAT_MIN = -24'sd32768;

    logic signed [31:0] w_prod1;
    logic signed [31:0] w_prod2;
    logic signed [33:0] w_acc;
    logic signed [22:0] w_pred;
    logic signed [19:0] w_scaled;
    logic signed [23:0] w_sum;

    // Prediction with rounding offset, floor shift by 11
    assign w_prod1 = i_c1 * i_newer;
    assign w_prod2 = i_c2 * i_older;
    assign w_acc   = 34'(w_prod1) + 34'(w_prod2) + 34'sd1024;
    assign w_pred  = w_acc[33:11];

    // Sign-extended nibble times a power-of-two scale
    assign w_scaled = $signed({{16{i_nibble[3]}}, i_nibble}) <<< i_shift;

    assign w_sum = 24'(w_pred) + 24'(w_scaled);

    // Clamp to 16 bits
    always_comb begin
        if (w_sum > SAT_MAX) begin
            o_sample = t_pcm'(SAT_MAX[PCM_W-1:0]);
        end else if (w_sum < SAT_MIN) begin
            o_sample = t_pcm'(SAT_MIN[PCM_W-1:0]);
        end else begin
            o_sample = t_pcm'(w_sum[PCM_W-1:0]);
        end
    end

endmodule

// ===== tb/dsp_adpcm_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// ADPCM decoder core testbench
// Streams 8-byte ADPCM frames into the core under several coefficient and
// history settings, predicts every PCM sample with a behavioral decoder and
// checks each output transaction against the oldest predicted sample.
// Both stream sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder_core_test;

    import adpcm_pkg::*;

    // Indexes past the register file; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int SETTLE_CYCLES = 16;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int NUM_PHASES = 6;
    localparam int TIMEOUT_UNITS = 1000000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              restart;
        logic              fin;
    } t_stream_item;

    typedef struct packed {
        t_pcm pcm;
        logic last;
    } t_pcm_result;

    // DUT ports; the inputs are known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [15:0]           o_m_tdata;
    logic                  o_m_tlast;

    // Shadow configuration and decoder state
    logic [63:0]       coef_shadow [4];
    t_pcm              start_newer_shadow;
    t_pcm              start_older_shadow;
    t_pcm              pred_newer;
    t_pcm              pred_older;
    logic [BYTE_W-1:0] pred_header;
    logic [POS_W-1:0]  pred_pos;

    t_stream_item byte_q [$];
    t_pcm_result  expected_pcm_q [$];

    int  mismatches = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    bit  calm = 1'b0;
    bit  resync = 1'b1;

    dsp_adpcm_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [7:0] stream_byte
        .i_s_tuser   (i_s_tuser),   // [0] restart
        .i_s_tlast   (i_s_tlast),   // final_half
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [15:0] pcm_sample
        .o_m_tlast   (o_m_tlast)    // last_of_byte
    );

    // Generate the clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Fetch a signed coefficient from the shadow packs
    function automatic longint coef_word(int k);
        logic [15:0] w;
        w = coef_shadow[k / 4][(k % 4) * 16 +: 16];
        return longint'($signed(w));
    endfunction

    // Decode one nibble against the current header and shift the history
    function automatic t_pcm decode_nibble(t_nibble nib);
        longint c1;
        longint c2;
        longint acc;
        longint s;
        int     pair;
        int     scale;
        pair  = int'(pred_header[6:4]);
        scale = int'(pred_header[3:0]);
        c1  = coef_word(2 * pair);
        c2  = coef_word(2 * pair + 1);
        acc = c1 * longint'(pred_newer) + c2 * longint'(pred_older) + 1024;
        s   = longint'($signed(nib)) * (longint'(1) << scale) + (acc >>> 11);
        if (s < -32768) s = -32768;
        if (s > 32767) s = 32767;
        pred_older = pred_newer;
        pred_newer = s[15:0];
        return pred_newer;
    endfunction

    // Queue the samples that one accepted byte produces
    task automatic decode_byte(logic [BYTE_W-1:0] data, logic restart, logic fin);
        t_pcm_result r;
        if (restart) begin
            pred_newer = start_newer_shadow;
            pred_older = start_older_shadow;
            pred_pos   = '0;
        end
        if (pred_pos == '0) begin
            pred_header = data;
            pred_pos    = 3'd1;
        end else begin
            pred_pos = pred_pos + 3'd1;
            r.pcm  = decode_nibble(data[7:4]);
            r.last = fin;
            expected_pcm_q.push_back(r);
            if (!fin) begin
                r.pcm  = decode_nibble(data[3:0]);
                r.last = 1'b1;
                expected_pcm_q.push_back(r);
            end
        end
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_COEF_PACK_A: coef_shadow[0] = value;
            REG_COEF_PACK_B: coef_shadow[1] = value;
            REG_COEF_PACK_C: coef_shadow[2] = value;
            REG_COEF_PACK_D: coef_shadow[3] = value;
            REG_START_NEWER: start_newer_shadow = value[15:0];
            REG_START_OLDER: start_older_shadow = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [63:0] d, t_pcm newer, t_pcm older);
        write_reg(REG_COEF_PACK_A, a);
        write_reg(REG_COEF_PACK_B, b);
        write_reg(REG_COEF_PACK_C, c);
        write_reg(REG_COEF_PACK_D, d);
        write_reg(REG_START_NEWER, {{48{newer[15]}}, newer});
        write_reg(REG_START_OLDER, {{48{older[15]}}, older});
    endtask

    // Four coefficients in the usual prediction range of about +/-2.0
    function automatic logic [63:0] typical_pack();
        logic [63:0] p;
        for (int i = 0; i < 4; i++) begin
            p[i * 16 +: 16] = 16'(int'($urandom_range(0, 8191)) - 4096);
        end
        return p;
    endfunction

    task automatic push_byte(logic [BYTE_W-1:0] data, logic restart, logic fin);
        t_stream_item it;
        it.data    = data;
        it.restart = restart;
        it.fin     = fin;
        byte_q.push_back(it);
    endtask

    // Add a frame with random content; now and then cut it short
    task automatic add_frame(ref int count);
        logic [3:0] sel;
        logic [3:0] scale;
        int         len;
        sel   = 4'($urandom_range(0, 15));
        scale = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 11));
        push_byte({sel, scale}, resync || ($urandom_range(0, 3) == 0),
                  ($urandom_range(0, 7) == 0));
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 7;
        resync = (len != 7);
        for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(0, 255)), 1'b0, ($urandom_range(0, 15) == 0));
        end
        count += len + 1;
    endtask

    // Wait for the stream to drain and the core to settle
    task automatic wait_idle();
        while (byte_q.size() != 0 || i_s_tvalid || expected_pcm_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive the encoded stream and predict each accepted transaction
    always @(posedge i_clk) begin : drive_proc
        t_stream_item nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(i_s_tdata, i_s_tuser, i_s_tlast);
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (byte_q.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(1, 8) - 1;
                    i_s_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    nxt = byte_q.pop_front();
                    i_s_tdata  <= nxt.data;
                    i_s_tuser  <= nxt.restart;
                    i_s_tlast  <= nxt.fin;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Accept PCM transactions and compare them with the oldest prediction
    always @(posedge i_clk) begin : monitor_proc
        t_pcm_result exp_r;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_pcm_q.size() == 0) begin
                    $error("pcm_sample: expected none, actual %0d", $signed(o_m_tdata));
                    mismatches++;
                end else begin
                    exp_r = expected_pcm_q.pop_front();
                    if (o_m_tdata !== exp_r.pcm) begin
                        $error("pcm_sample: expected %0d, actual %0d",
                               exp_r.pcm, $signed(o_m_tdata));
                        mismatches++;
                    end
                    if (o_m_tlast !== exp_r.last) begin
                        $error("last_of_byte: expected %0b, actual %0b",
                               exp_r.last, o_m_tlast);
                        mismatches++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 8) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Sequence reset, configuration phases and stimulus
    initial begin : stim_proc
        int count;
        for (int i = 0; i < 4; i++) coef_shadow[i] = '0;
        start_newer_shadow = '0;
        start_older_shadow = '0;
        pred_newer  = '0;
        pred_older  = '0;
        pred_header = '0;
        pred_pos    = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: typical predictor, history at both extremes
        write_all(typical_pack(), typical_pack(), typical_pack(), typical_pack(),
                  16'sh7FFF, 16'sh8000);
        write_reg(REG_SPARE_LO, {$urandom, $urandom});
        write_reg(REG_SPARE_HI, {$urandom, $urandom});

        // Restart header with the final flag set, then a full frame of extremes
        push_byte(8'h0C, 1'b1, 1'b1);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h08, 1'b0, 1'b0);
        push_byte(8'hF0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h77, 1'b0, 1'b0);
        // Header after end of frame, selector past seven, largest scale
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h88, 1'b0, 1'b0);
        push_byte(8'h37, 1'b0, 1'b1);
        push_byte(8'h12, 1'b0, 1'b0);
        push_byte(8'h34, 1'b0, 1'b0);
        push_byte(8'h56, 1'b0, 1'b1);
        push_byte(8'h9A, 1'b0, 1'b0);
        push_byte(8'h8B, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b0, 1'b0);
        // Restart in the middle of a frame
        push_byte(8'h30, 1'b1, 1'b0);
        push_byte(8'hC3, 1'b0, 1'b1);
        push_byte(8'h5E, 1'b0, 1'b0);
        wait_idle();

        // Random frames under a new setting per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_all(typical_pack(), typical_pack(), typical_pack(), typical_pack(),
                             t_pcm'($urandom), t_pcm'($urandom));
                1: write_all({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                             16'sh7FFF, 16'sh7FFF);
                2: write_all({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                             16'sh8000, 16'sh7FFF);
                3: write_all('0, '0, '0, '0, 16'sh0000, 16'sh8000);
                4: write_all({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom},
                             t_pcm'($urandom), t_pcm'($urandom));
                default: begin
                    write_all(typical_pack(), typical_pack(), typical_pack(),
                              typical_pack(), t_pcm'($urandom), t_pcm'($urandom));
                    calm = 1'b1;
                end
            endcase
            resync = 1'b1;
            count  = 0;
            while (count < ITEMS_PER_PHASE) add_frame(count);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Bound the run
    initial begin : watchdog_proc
        #(TIMEOUT_UNITS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
